@@ hw/rtl/first_fit_gap_allocator_core_defines.svh @@
// Assertion helpers shared by the allocator RTL.
`ifndef FIRST_FIT_GAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_GAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define FFGA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication.
`define FFGA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

@@ hw/rtl/ffga_pkg.sv @@
package ffga_pkg;

    localparam int ADDR_W         = 32;
    localparam int LEN_W          = 25;
    localparam int DEF_MAX_GAPS   = 64;
    localparam int DEF_MAX_ALLOCS = 256;
    localparam int ALIGN          = 16;
    localparam int ALIGN_W        = $clog2(ALIGN);
    localparam logic [LEN_W-1:0] HEAP_LENGTH_RESET = LEN_W'(10240);

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    localparam logic REG_HEAP_BASE   = 1'b0;
    localparam logic REG_HEAP_LENGTH = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } t_gap;

    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } t_alloc;

    localparam int GAP_W   = $bits(t_gap);
    localparam int ALLOC_W = $bits(t_alloc);

endpackage

@@ hw/rtl/ffga_ram.sv @@
module ffga_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 57
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/first_fit_gap_allocator_core.sv @@
// From the input transfer to the result strobe: initialize, unknown ops and early failures
// finish straight from idle. Allocate scans the gaps, then the alloc entries, and shifts
// gap entries down when a gap is used up. Release scans the alloc entries and stops there
// for the last live allocation, else scans the gaps and shifts gap entries up when a new
// gap is inserted. One item at a time; the receiver cannot stall the result.
// Synchronous active-low reset clears gap count, valid bits and totals; no clearing pass.
module first_fit_gap_allocator_core #(
    parameter int MAX_GAPS   = ffga_pkg::DEF_MAX_GAPS,
    parameter int MAX_ALLOCS = ffga_pkg::DEF_MAX_ALLOCS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [ffga_pkg::ADDR_W-1:0]       i_cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_operation,
    input  logic [ffga_pkg::LEN_W-1:0]        i_request_size,
    input  logic [ffga_pkg::ADDR_W-1:0]       i_release_address,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic [ffga_pkg::ADDR_W-1:0]       o_granted_address,
    output logic [ffga_pkg::LEN_W-1:0]        o_used_bytes,
    output logic [$clog2(MAX_ALLOCS+1)-1:0]   o_live_count
);

    `include "first_fit_gap_allocator_core_defines.svh"

    localparam int GIW = $clog2(MAX_GAPS);
    localparam int GCW = $clog2(MAX_GAPS + 1);
    localparam int AIW = $clog2(MAX_ALLOCS);
    localparam int CW  = $clog2(MAX_ALLOCS + 1);
    localparam int AW  = ffga_pkg::ADDR_W;
    localparam int LW  = ffga_pkg::LEN_W;
    localparam int PW  = ffga_pkg::ALIGN_W;

    typedef enum logic [3:0] {
        S_IDLE, S_AGAP, S_AKEY, S_ACOMMIT, S_ADEL,
        S_RKEY, S_RGAP, S_RDECIDE, S_RINS, S_RPUT
    } t_state;

    t_state              r_state;
    logic [LW-1:0]       r_size;
    logic [AW-1:0]       r_key;
    logic [GCW-1:0]      r_gi;
    logic [GCW-1:0]      r_gk;
    logic [AIW-1:0]      r_k;
    logic [AW-1:0]       r_gs;
    logic [LW-1:0]       r_gl;
    logic [LW-1:0]       r_need;
    logic                r_hit;
    logic [AIW-1:0]      r_slot;
    logic [AIW-1:0]      r_free;
    logic                r_free_ok;
    logic [LW-1:0]       r_oldreq;
    logic [AW-1:0]       r_rstart;
    logic [LW-1:0]       r_rlen;
    logic                r_jhas;
    logic [GCW-1:0]      r_gap_count;
    logic [LW-1:0]       r_used;
    logic [CW-1:0]       r_live;
    logic [AW-1:0]       r_base;
    logic [LW-1:0]       r_hlen;
    logic [MAX_ALLOCS-1:0] r_valid;
    logic                r_done;
    ffga_pkg::t_status   r_status;
    logic [AW-1:0]       r_granted;

    logic                  g_we;
    logic [GIW-1:0]        g_waddr;
    ffga_pkg::t_gap        g_wdata;
    logic [GIW-1:0]        g_raddr;
    logic [ffga_pkg::GAP_W-1:0] g_q;
    logic                  a_we;
    logic [AIW-1:0]        a_waddr;
    ffga_pkg::t_alloc      a_wdata;
    logic [AIW-1:0]        a_raddr;
    logic [ffga_pkg::ALLOC_W-1:0] a_q;

    ffga_pkg::t_gap   gq;
    ffga_pkg::t_alloc aq;
    ffga_pkg::t_op    in_op;
    logic             accept;
    logic             init_acc;
    logic [PW-1:0]    pad;
    logic [LW:0]      need;
    logic             fit;
    logic             a_hit;
    logic             a_last;
    logic             g_last;
    logic [AW-1:0]    oldpad;
    logic [LW-1:0]    oldreq;
    logic [GCW-1:0]   gi1;
    logic [GCW-1:0]   gi2;
    logic [AIW-1:0]   k1;
    logic             do_onegap;
    logic             merge;
    logic [LW:0]      merge_sum;
    logic [LW-1:0]    merge_len;
    logic [LW-1:0]    alloc_sub;
    logic [LW-1:0]    alloc_base;
    logic [LW:0]      alloc_sum;
    logic [LW-1:0]    alloc_used;
    logic [LW-1:0]    rel_used;

    ffga_ram #(.DEPTH(MAX_GAPS), .WIDTH(ffga_pkg::GAP_W)) u_gap_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_q)
    );

    ffga_ram #(.DEPTH(MAX_ALLOCS), .WIDTH(ffga_pkg::ALLOC_W)) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_q)
    );

    always_comb begin
        gq        = ffga_pkg::t_gap'(g_q);
        aq        = ffga_pkg::t_alloc'(a_q);
        in_op     = ffga_pkg::t_op'(i_operation);
        accept    = start && (r_state == S_IDLE);
        init_acc  = accept && in_op == ffga_pkg::OP_INIT;
        pad       = PW'(0) - gq.start[PW-1:0];
        need      = {1'b0, r_size} + (LW+1)'(pad);
        fit       = need <= {1'b0, gq.len};
        a_hit     = r_valid[r_k] && (aq.key == r_key);
        a_last    = r_k == AIW'(MAX_ALLOCS - 1);
        gi1       = r_gi + GCW'(1);
        gi2       = r_gi + GCW'(2);
        g_last    = gi1 == r_gap_count;
        k1        = r_k + AIW'(1);
        oldpad    = aq.key - aq.start;
        oldreq    = ({{(AW-LW){1'b0}}, aq.len} >= oldpad) ? (aq.len - oldpad[LW-1:0]) : '0;
        do_onegap = init_acc ||
                    (r_state == S_RKEY && a_hit && r_live == CW'(1));
        merge     = r_jhas && ((r_rstart + AW'(r_rlen)) == r_gs);
        merge_sum = {1'b0, r_gl} + {1'b0, r_rlen};
        merge_len = merge_sum[LW] ? '1 : merge_sum[LW-1:0];
        alloc_sub = (r_hit) ? ((r_oldreq <= r_used) ? r_oldreq : r_used) : '0;
        alloc_base = r_used - alloc_sub;
        alloc_sum = {1'b0, alloc_base} + {1'b0, r_size};
        alloc_used = alloc_sum[LW] ? '1 : alloc_sum[LW-1:0];
        rel_used  = r_used - ((r_oldreq <= r_used) ? r_oldreq : r_used);
    end

    always_comb begin
        g_we    = 1'b0;
        g_waddr = r_gi[GIW-1:0];
        g_wdata = '0;
        g_raddr = gi1[GIW-1:0];
        a_we    = 1'b0;
        a_waddr = r_slot;
        a_wdata = '0;
        a_raddr = k1;
        if (do_onegap) begin
            g_we    = r_hlen != '0;
            g_waddr = '0;
            g_wdata = '{start: r_base, len: r_hlen};
        end
        case (r_state)
            S_IDLE: begin
                g_raddr = '0;
                a_raddr = '0;
            end
            S_AGAP: begin
                a_raddr = '0;
            end
            S_ACOMMIT: begin
                a_we    = 1'b1;
                a_wdata = '{key: r_key, start: r_gs, len: r_need};
                if (r_need != r_gl) begin
                    g_we    = 1'b1;
                    g_wdata = '{start: r_gs + AW'(r_need), len: r_gl - r_need};
                end
            end
            S_ADEL: begin
                g_we    = 1'b1;
                g_wdata = gq;
                g_raddr = gi2[GIW-1:0];
            end
            S_RKEY: begin
                g_raddr = '0;
            end
            S_RDECIDE: begin
                g_raddr = GIW'(r_gap_count - GCW'(1));
                if (merge) begin
                    g_we    = 1'b1;
                    g_wdata = '{start: r_rstart, len: merge_len};
                end
            end
            S_RINS: begin
                g_we    = 1'b1;
                g_waddr = r_gk[GIW-1:0];
                g_wdata = gq;
                g_raddr = GIW'(r_gk - GCW'(2));
            end
            S_RPUT: begin
                g_we    = 1'b1;
                g_wdata = '{start: r_rstart, len: r_rlen};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gap_count <= '0;
            r_used      <= '0;
            r_live      <= '0;
            r_valid     <= '0;
            r_done      <= 1'b0;
            r_status    <= ffga_pkg::ST_OK;
            r_granted   <= '0;
            r_base      <= '0;
            r_hlen      <= ffga_pkg::HEAP_LENGTH_RESET;
            r_free_ok   <= 1'b0;
            r_hit       <= 1'b0;
            r_jhas      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ffga_pkg::REG_HEAP_BASE:   r_base <= i_cfg_data;
                    ffga_pkg::REG_HEAP_LENGTH: r_hlen <= i_cfg_data[LW-1:0];
                    default: begin
                    end
                endcase
            end
            if (do_onegap) begin
                r_gap_count <= (r_hlen != '0) ? GCW'(1) : '0;
                r_valid     <= '0;
                r_used      <= '0;
                r_live      <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_size    <= i_request_size;
                        r_key     <= i_release_address;
                        r_gi      <= '0;
                        r_k       <= '0;
                        r_granted <= '0;
                        r_status  <= ffga_pkg::ST_OK;
                        case (in_op)
                            ffga_pkg::OP_ALLOC: begin
                                if (i_request_size == '0) begin
                                    r_status <= ffga_pkg::ST_NO_SPACE;
                                    r_done   <= 1'b1;
                                end else if (r_live >= CW'(MAX_ALLOCS)) begin
                                    r_status <= ffga_pkg::ST_FULL;
                                    r_done   <= 1'b1;
                                end else if (r_gap_count == '0) begin
                                    r_status <= ffga_pkg::ST_NO_SPACE;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_AGAP;
                                end
                            end
                            ffga_pkg::OP_RELEASE: r_state <= S_RKEY;
                            default: r_done <= 1'b1;
                        endcase
                    end
                end
                S_AGAP: begin
                    if (fit) begin
                        r_gs      <= gq.start;
                        r_gl      <= gq.len;
                        r_need    <= need[LW-1:0];
                        r_key     <= gq.start + AW'(pad);
                        r_k       <= '0;
                        r_free_ok <= 1'b0;
                        r_state   <= S_AKEY;
                    end else if (g_last) begin
                        r_status <= ffga_pkg::ST_NO_SPACE;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_gi <= gi1;
                    end
                end
                S_AKEY: begin
                    if (!r_valid[r_k] && !r_free_ok) begin
                        r_free    <= r_k;
                        r_free_ok <= 1'b1;
                    end
                    if (a_hit) begin
                        r_hit    <= 1'b1;
                        r_slot   <= r_k;
                        r_oldreq <= oldreq;
                        r_state  <= S_ACOMMIT;
                    end else if (a_last) begin
                        r_hit   <= 1'b0;
                        r_slot  <= r_free_ok ? r_free : r_k;
                        r_state <= S_ACOMMIT;
                    end else begin
                        r_k <= k1;
                    end
                end
                S_ACOMMIT: begin
                    r_valid[r_slot] <= 1'b1;
                    r_used          <= alloc_used;
                    if (!r_hit) begin
                        r_live <= r_live + CW'(1);
                    end
                    if (r_need == r_gl && gi1 < r_gap_count) begin
                        r_state <= S_ADEL;
                    end else begin
                        if (r_need == r_gl) begin
                            r_gap_count <= r_gap_count - GCW'(1);
                        end
                        r_granted <= r_key;
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_ADEL: begin
                    if (gi2 < r_gap_count) begin
                        r_gi <= gi1;
                    end else begin
                        r_gap_count <= r_gap_count - GCW'(1);
                        r_granted   <= r_key;
                        r_done      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_RKEY: begin
                    if (a_hit) begin
                        if (r_live == CW'(1)) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_rstart <= aq.start;
                            r_rlen   <= aq.len;
                            r_oldreq <= oldreq;
                            r_slot   <= r_k;
                            r_gi     <= '0;
                            r_jhas   <= 1'b0;
                            r_state  <= (r_gap_count == '0) ? S_RDECIDE : S_RGAP;
                        end
                    end else if (a_last) begin
                        r_status <= ffga_pkg::ST_UNKNOWN;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_k <= k1;
                    end
                end
                S_RGAP: begin
                    if (r_rstart < gq.start) begin
                        r_jhas  <= 1'b1;
                        r_gs    <= gq.start;
                        r_gl    <= gq.len;
                        r_state <= S_RDECIDE;
                    end else begin
                        r_gi <= gi1;
                        if (g_last) begin
                            r_state <= S_RDECIDE;
                        end
                    end
                end
                S_RDECIDE: begin
                    r_gk <= r_gap_count;
                    if (merge) begin
                        r_used        <= rel_used;
                        r_valid[r_slot] <= 1'b0;
                        r_live        <= r_live - CW'(1);
                        r_done        <= 1'b1;
                        r_state       <= S_IDLE;
                    end else if (r_gap_count >= GCW'(MAX_GAPS)) begin
                        r_status <= ffga_pkg::ST_FULL;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= (r_gap_count > r_gi) ? S_RINS : S_RPUT;
                    end
                end
                S_RINS: begin
                    if ((r_gk - GCW'(1)) > r_gi) begin
                        r_gk <= r_gk - GCW'(1);
                    end else begin
                        r_state <= S_RPUT;
                    end
                end
                S_RPUT: begin
                    r_gap_count     <= r_gap_count + GCW'(1);
                    r_used          <= rel_used;
                    r_valid[r_slot] <= 1'b0;
                    r_live          <= r_live - CW'(1);
                    r_done          <= 1'b1;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy              = r_state != S_IDLE;
    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_granted_address = r_granted;
    assign o_used_bytes      = r_used;
    assign o_live_count      = r_live;

    `FFGA_ASSERT_IMP(a_live_bound, i_clk, i_rst_n, 1'b1, r_live <= CW'(MAX_ALLOCS))
    `FFGA_ASSERT_IMP(a_gap_bound, i_clk, i_rst_n, 1'b1, r_gap_count <= GCW'(MAX_GAPS))
    `FFGA_ASSERT_IMP(a_fail_no_addr, i_clk, i_rst_n, r_status != ffga_pkg::ST_OK, r_granted == '0)
    `FFGA_ASSERT_NXT(a_init_clears, i_clk, i_rst_n, init_acc, o_done && r_live == '0 && r_used == '0)
    `FFGA_ASSERT_NXT(a_accept_moves, i_clk, i_rst_n, accept, busy || o_done)

endmodule
